FILE: rtl/fsk_pkg.sv
// fsk_pkg: shared types, register indexes, filter coefficients and the bandpass step
`default_nettype none
package fsk_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MARK_STEP   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SPACE_STEP  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_LIMIT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_DELAY    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_DELAY   = 3'd5;

    localparam logic        MODE_V21 = 1'b0;
    localparam logic        MODE_ORG = 1'b1;

    localparam logic        RST_FILTER_MODE = MODE_V21;
    localparam logic [6:0]  RST_MARK_STEP   = 7'd10;
    localparam logic [6:0]  RST_SPACE_STEP  = 7'd12;
    localparam logic [7:0]  RST_LEVEL_LIMIT = 8'd50;
    localparam logic [15:0] RST_ON_DELAY    = 16'd1253;
    localparam logic [15:0] RST_OFF_DELAY   = 16'd6269;

    // coefficients as h = a*diff + b1*y1 - b2*y2, so b1 carries its sign
    localparam logic signed [8:0] MARK_A_V21   = 9'sd24;
    localparam logic signed [8:0] MARK_B1_V21  = 9'sd72;
    localparam logic signed [8:0] MARK_B2_V21  = 9'sd244;
    localparam logic signed [8:0] SPACE_A_V21  = 9'sd32;
    localparam logic signed [8:0] SPACE_B1_V21 = 9'sd32;
    localparam logic signed [8:0] SPACE_B2_V21 = 9'sd248;
    localparam logic signed [8:0] SPACE_A_ORG  = 9'sd67;
    localparam logic signed [8:0] SPACE_B1_ORG = 9'sd87;
    localparam logic signed [8:0] SPACE_B2_ORG = 9'sd99;
    localparam logic signed [8:0] MARK_A_ORG   = 9'sd80;
    localparam logic signed [8:0] MARK_B1_ORG  = -9'sd19;
    localparam logic signed [8:0] MARK_B2_ORG  = 9'sd102;

    typedef struct packed {
        logic signed [7:0] line_sample;
        logic              send_on;
        logic              send_mark;
    } in_t;

    typedef struct packed {
        logic [6:0]        tone_phase;
        logic              carrier_mark;
        logic              reported_mark;
        logic              line_on;
        logic signed [7:0] mark_level;
        logic signed [7:0] space_level;
    } res_t;

    typedef struct packed {
        logic        filter_mode;
        logic [6:0]  mark_step;
        logic [6:0]  space_step;
        logic [7:0]  level_limit;
        logic [15:0] on_delay;
        logic [15:0] off_delay;
    } cfg_t;

    // one second-order section; v21 form adds y1 after a shift by 8, original form shifts by 7
    function automatic logic signed [7:0] bp_step(
        input logic signed [8:0] diff,
        input logic signed [7:0] y1,
        input logic signed [7:0] y2,
        input logic signed [8:0] ca,
        input logic signed [8:0] cb1,
        input logic signed [8:0] cb2,
        input logic              mode
    );
        logic signed [19:0] acc;
        logic signed [15:0] h;
        logic signed [15:0] sh;
        logic        [7:0]  sum;
        acc = 20'(ca) * 20'(diff) + 20'(cb1) * 20'(y1) - 20'(cb2) * 20'(y2);
        h   = acc[15:0];
        if (mode == MODE_ORG)
        begin
            sh  = h >>> 7;
            sum = sh[7:0];
        end
        else
        begin
            sh  = h >>> 8;
            sum = sh[7:0] + y1;
        end
        return sum;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fsk_filter.sv
// fsk_filter: mark and space bandpass filters with their sample and output history
`default_nettype none
module fsk_filter (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   mode,
    input  wire logic signed [7:0]      sample,
    output logic signed [7:0]           mark_out,
    output logic signed [7:0]           space_out
);

    logic signed [7:0] x1_reg, x2_reg, m1_reg, m2_reg, s1_reg, s2_reg;
    logic signed [8:0] diff;

    assign diff = $signed({sample[7], sample}) - $signed({x2_reg[7], x2_reg});

    always_comb
    begin
        if (mode == fsk_pkg::MODE_ORG)
        begin
            mark_out  = fsk_pkg::bp_step(diff, m1_reg, m2_reg, fsk_pkg::MARK_A_ORG,
                                         fsk_pkg::MARK_B1_ORG, fsk_pkg::MARK_B2_ORG, mode);
            space_out = fsk_pkg::bp_step(diff, s1_reg, s2_reg, fsk_pkg::SPACE_A_ORG,
                                         fsk_pkg::SPACE_B1_ORG, fsk_pkg::SPACE_B2_ORG, mode);
        end
        else
        begin
            mark_out  = fsk_pkg::bp_step(diff, m1_reg, m2_reg, fsk_pkg::MARK_A_V21,
                                         fsk_pkg::MARK_B1_V21, fsk_pkg::MARK_B2_V21, mode);
            space_out = fsk_pkg::bp_step(diff, s1_reg, s2_reg, fsk_pkg::SPACE_A_V21,
                                         fsk_pkg::SPACE_B1_V21, fsk_pkg::SPACE_B2_V21, mode);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            m1_reg <= '0;
            m2_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (adv)
        begin
            x2_reg <= x1_reg;
            x1_reg <= sample;
            m2_reg <= m1_reg;
            m1_reg <= mark_out;
            s2_reg <= s1_reg;
            s1_reg <= space_out;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fsk_decide.sv
// fsk_decide: rectifier, smoothing counter, space lock, on/off timer and tone phase
`default_nettype none
module fsk_decide (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire fsk_pkg::cfg_t          cfg,
    input  wire logic                   send_on,
    input  wire logic                   send_mark,
    input  wire logic signed [7:0]      mark_out,
    input  wire logic signed [7:0]      space_out,
    output fsk_pkg::res_t               res
);

    logic [7:0]  cnt_reg, cnt_next;
    logic        flag_reg, flag_next;
    logic        lock_reg, lock_next;
    logic        on_reg, on_next;
    logic [15:0] dly_reg, dly_next;
    logic [6:0]  phase_reg, phase_next;

    logic signed [7:0] mark_lvl, space_lvl;
    logic        [16:0] dly_inc;
    logic        [15:0] limit;
    logic               send_tone_mark;

    // negating -128 wraps back to -128
    assign mark_lvl  = mark_out[7] ? 8'(-mark_out) : mark_out;
    assign space_lvl = space_out[7] ? 8'(-space_out) : space_out;

    assign send_tone_mark = send_on && send_mark;
    assign limit   = flag_next ? cfg.on_delay : cfg.off_delay;
    assign dly_inc = {1'b0, dly_reg} + 17'd1;

    always_comb
    begin
        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        if (mark_lvl > space_lvl)
        begin
            if (cnt_reg < cfg.level_limit)
                cnt_next = cnt_reg + 8'd1;
            else
                flag_next = 1'b1;
        end
        else
        begin
            if (cnt_reg != 8'd0)
                cnt_next = cnt_reg - 8'd1;
            else
                flag_next = 1'b0;
        end

        lock_next = (lock_reg || !send_tone_mark) && !flag_next;

        on_next  = on_reg;
        dly_next = dly_reg + 16'd1;
        if (on_reg == flag_next)
            dly_next = '0;
        else if (dly_inc >= {1'b0, limit})
        begin
            on_next  = flag_next;
            dly_next = '0;
        end

        phase_next = phase_reg + (send_tone_mark ? cfg.mark_step : cfg.space_step);

        res.tone_phase    = phase_next;
        res.carrier_mark  = flag_next;
        res.reported_mark = flag_next || lock_next;
        res.line_on       = on_next;
        res.mark_level    = mark_lvl;
        res.space_level   = space_lvl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flag_reg  <= 1'b0;
            lock_reg  <= 1'b0;
            on_reg    <= 1'b0;
            dly_reg   <= '0;
            phase_reg <= '0;
        end
        else if (adv)
        begin
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
            lock_reg  <= lock_next;
            on_reg    <= on_next;
            dly_reg   <= dly_next;
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (cnt_reg == $past(cnt_reg) + 8'd1 || cnt_reg == $past(cnt_reg) - 8'd1
                 || cnt_reg == $past(cnt_reg)))
        else $error("smoothing counter moved by more than one");
    a_lock_clear: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> !lock_reg)
        else $error("space lock held while mark decided");
    a_dly_idle: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (on_reg == flag_next) |=> dly_reg == 16'd0)
        else $error("delay counter running with no pending change");
`endif

endmodule
`default_nettype wire

FILE: rtl/fsk_tone_demodulator.sv
// fsk_tone_demodulator: top level with input register, configuration and result register
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  fsk_pkg::in_t
//  out       source     out_valid/out_stall  fsk_pkg::res_t
//  cfg       sink       cfg_we               cfg_addr, cfg_wdata
//
// one sample per cycle sustained while out_stall is low; a sample is held in the input register and
// its result is captured in the result register when the sample advances
// the filter and counter state loops close combinationally between the input and result registers
// reset clears all filter history, counters, flags and phase and restores register defaults
// a stalled result holds; the input register then fills and stalls the input side
`default_nettype none
module fsk_tone_demodulator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire fsk_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output fsk_pkg::res_t                        out_data,
    input  wire logic                            cfg_we,
    input  wire logic [fsk_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [fsk_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    fsk_pkg::cfg_t cfg_reg;
    fsk_pkg::in_t  in_data_reg;
    logic          in_valid_reg;
    fsk_pkg::res_t out_data_reg;
    logic          out_valid_reg;
    fsk_pkg::res_t res;

    logic              advance;
    logic              in_take;
    logic signed [7:0] mark_out, space_out;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_mode <= fsk_pkg::RST_FILTER_MODE;
            cfg_reg.mark_step   <= fsk_pkg::RST_MARK_STEP;
            cfg_reg.space_step  <= fsk_pkg::RST_SPACE_STEP;
            cfg_reg.level_limit <= fsk_pkg::RST_LEVEL_LIMIT;
            cfg_reg.on_delay    <= fsk_pkg::RST_ON_DELAY;
            cfg_reg.off_delay   <= fsk_pkg::RST_OFF_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fsk_pkg::REG_FILTER_MODE: cfg_reg.filter_mode <= cfg_wdata[0];
                fsk_pkg::REG_MARK_STEP:   cfg_reg.mark_step   <= cfg_wdata[6:0];
                fsk_pkg::REG_SPACE_STEP:  cfg_reg.space_step  <= cfg_wdata[6:0];
                fsk_pkg::REG_LEVEL_LIMIT: cfg_reg.level_limit <= cfg_wdata[7:0];
                fsk_pkg::REG_ON_DELAY:    cfg_reg.on_delay    <= cfg_wdata;
                fsk_pkg::REG_OFF_DELAY:   cfg_reg.off_delay   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= res;
    end

    fsk_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (advance),
        .mode      (cfg_reg.filter_mode),
        .sample    (in_data_reg.line_sample),
        .mark_out  (mark_out),
        .space_out (space_out)
    );

    fsk_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (advance),
        .cfg       (cfg_reg),
        .send_on   (in_data_reg.send_on),
        .send_mark (in_data_reg.send_mark),
        .mark_out  (mark_out),
        .space_out (space_out),
        .res       (res)
    );

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed sample produced no result");
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("waiting sample dropped");
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.carrier_mark |-> out_data_reg.reported_mark)
        else $error("mark decided but not reported");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_fsk_tone_demodulator.sv
// self-checking testbench for the fsk tone demodulator: directed table, tone bursts, noise
`timescale 1ns / 100ps
`default_nettype none
module tb_fsk_tone_demodulator;
    import fsk_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int N_PHASES     = 10;
    localparam int PHASE_ITEMS  = 112;
    localparam int N_DIRECTED   = 18;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    // filter coefficients, h = a*diff + b1*y1 - b2*y2 (original mark section subtracts b1)
    localparam int MK_A_V21  = 24;
    localparam int MK_B1_V21 = 72;
    localparam int MK_B2_V21 = 244;
    localparam int SP_A_V21  = 32;
    localparam int SP_B1_V21 = 32;
    localparam int SP_B2_V21 = 248;
    localparam int SP_A_ORG  = 67;
    localparam int SP_B1_ORG = 87;
    localparam int SP_B2_ORG = 99;
    localparam int MK_A_ORG  = 80;
    localparam int MK_B1_ORG = 19;
    localparam int MK_B2_ORG = 102;

    typedef struct packed {
        logic typed;
        in_t  stim;
        res_t want;
    } dir_row_t;

    // first two rows after reset worked out by hand, the rest go through the predictor
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{1'b1, '{8'h7F, 1'b1, 1'b1}, '{7'd10, 1'b0, 1'b0, 1'b0, 8'h0B, 8'h0F}},
        '{1'b1, '{8'h80, 1'b0, 1'b0}, '{7'd22, 1'b0, 1'b1, 1'b0, 8'h02, 8'h00}},
        '{1'b0, '{8'h7F, 1'b1, 1'b0}, '0},
        '{1'b0, '{8'h80, 1'b0, 1'b1}, '0},
        '{1'b0, '{8'h00, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'hFF, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h7F, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h7F, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h80, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h80, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h7F, 1'b0, 1'b0}, '0},
        '{1'b0, '{8'h80, 1'b0, 1'b0}, '0},
        '{1'b0, '{8'h7F, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h80, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'h00, 1'b0, 1'b1}, '0},
        '{1'b0, '{8'h00, 1'b1, 1'b0}, '0},
        '{1'b0, '{8'h55, 1'b1, 1'b1}, '0},
        '{1'b0, '{8'hAA, 1'b1, 1'b1}, '0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    res_t                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic        mode_q    = MODE_V21;
    logic [6:0]  mark_inc  = 7'd10;
    logic [6:0]  space_inc = 7'd12;
    logic [7:0]  limit_q   = 8'd50;
    logic [15:0] on_dly    = 16'd1253;
    logic [15:0] off_dly   = 16'd6269;

    // predictor copy of the filter history, counters and flags
    logic signed [7:0] x_hist1  = '0;
    logic signed [7:0] x_hist2  = '0;
    logic signed [7:0] mark_y1  = '0;
    logic signed [7:0] mark_y2  = '0;
    logic signed [7:0] space_y1 = '0;
    logic signed [7:0] space_y2 = '0;
    logic [7:0]  smooth_count = '0;
    logic        mark_dec     = 1'b0;
    logic        space_lock_q = 1'b0;
    logic        line_on_q    = 1'b0;
    logic [15:0] onoff_count  = '0;
    logic [6:0]  phase_acc    = '0;

    res_t pending_results [$];
    res_t front_result;
    int   mismatches  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    bit   quiet       = 1'b0;

    fsk_tone_demodulator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    task automatic demod_predict(input in_t s, output res_t r);
        int                diff;
        logic signed [15:0] acc;
        logic signed [7:0]  ym;
        logic signed [7:0]  ys;
        logic signed [7:0]  ym_abs;
        logic signed [7:0]  ys_abs;
        logic [6:0]         inc;
        if (s.send_on && s.send_mark)
            inc = mark_inc;
        else
        begin
            inc = space_inc;
            space_lock_q = 1'b1;
        end
        diff = int'($signed(s.line_sample)) - int'(x_hist2);
        if (mode_q == MODE_V21)
        begin
            acc = MK_A_V21 * diff + MK_B1_V21 * int'(mark_y1) - MK_B2_V21 * int'(mark_y2);
            ym  = (acc >>> 8) + mark_y1;
            acc = SP_A_V21 * diff + SP_B1_V21 * int'(space_y1) - SP_B2_V21 * int'(space_y2);
            ys  = (acc >>> 8) + space_y1;
        end
        else
        begin
            acc = SP_A_ORG * diff + SP_B1_ORG * int'(space_y1) - SP_B2_ORG * int'(space_y2);
            ys  = acc >>> 7;
            acc = MK_A_ORG * diff - MK_B1_ORG * int'(mark_y1) - MK_B2_ORG * int'(mark_y2);
            ym  = acc >>> 7;
        end
        x_hist2  = x_hist1;
        x_hist1  = s.line_sample;
        mark_y2  = mark_y1;
        mark_y1  = ym;
        space_y2 = space_y1;
        space_y1 = ys;
        // rectifying -128 wraps back to -128
        ym_abs = (ym < 0) ? -ym : ym;
        ys_abs = (ys < 0) ? -ys : ys;
        if (ym_abs > ys_abs)
        begin
            if (smooth_count < limit_q)
                smooth_count = smooth_count + 8'd1;
            else
                mark_dec = 1'b1;
        end
        else
        begin
            if (smooth_count != 8'd0)
                smooth_count = smooth_count - 8'd1;
            else
                mark_dec = 1'b0;
        end
        if (mark_dec)
            space_lock_q = 1'b0;
        // delay test is done in 17 bits so a zero delay switches at once
        if (mark_dec)
        begin
            if (line_on_q)
                onoff_count = '0;
            else if ({1'b0, onoff_count} + 17'd1 >= {1'b0, on_dly})
            begin
                line_on_q   = 1'b1;
                onoff_count = '0;
            end
            else
                onoff_count = onoff_count + 16'd1;
        end
        else
        begin
            if (!line_on_q)
                onoff_count = '0;
            else if ({1'b0, onoff_count} + 17'd1 >= {1'b0, off_dly})
            begin
                line_on_q   = 1'b0;
                onoff_count = '0;
            end
            else
                onoff_count = onoff_count + 16'd1;
        end
        phase_acc = phase_acc + inc;
        r.tone_phase    = phase_acc;
        r.carrier_mark  = mark_dec;
        r.reported_mark = mark_dec | space_lock_q;
        r.line_on       = line_on_q;
        r.mark_level    = ym_abs;
        r.space_level   = ys_abs;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            REG_FILTER_MODE: mode_q    = value[0];
            REG_MARK_STEP:   mark_inc  = value[6:0];
            REG_SPACE_STEP:  space_inc = value[6:0];
            REG_LEVEL_LIMIT: limit_q   = value[7:0];
            REG_ON_DELAY:    on_dly    = value[15:0];
            REG_OFF_DELAY:   off_dly   = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input int unsigned mode, input int unsigned m_inc,
                                 input int unsigned s_inc, input int unsigned lim,
                                 input int unsigned on_d, input int unsigned off_d);
        write_reg(REG_FILTER_MODE, mode);
        write_reg(REG_MARK_STEP, m_inc);
        write_reg(REG_SPACE_STEP, s_inc);
        write_reg(REG_LEVEL_LIMIT, lim);
        write_reg(REG_ON_DELAY, on_d);
        write_reg(REG_OFF_DELAY, off_d);
        cfg_we <= 1'b0;
    endtask

    // waits until every expected result is back, block is idle after that
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_sample(input in_t s, input bit use_want, input res_t want);
        res_t pred;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        demod_predict(s, pred);
        pending_results.push_back(use_want ? want : pred);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing expected at cycle %0d", cycle_count);
            end
            else
            begin
                front_result = pending_results.pop_front();
                if (out_data.tone_phase    !== front_result.tone_phase    ||
                    out_data.carrier_mark  !== front_result.carrier_mark  ||
                    out_data.reported_mark !== front_result.reported_mark ||
                    out_data.line_on       !== front_result.line_on       ||
                    out_data.mark_level    !== front_result.mark_level    ||
                    out_data.space_level   !== front_result.space_level)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at cycle %0d: phase %0d/%0d carrier %0b/%0b ",
                                  "reported %0b/%0b line_on %0b/%0b mark %0d/%0d ",
                                  "space %0d/%0d (expected/actual)"},
                                 cycle_count,
                                 front_result.tone_phase, out_data.tone_phase,
                                 front_result.carrier_mark, out_data.carrier_mark,
                                 front_result.reported_mark, out_data.reported_mark,
                                 front_result.line_on, out_data.line_on,
                                 front_result.mark_level, out_data.mark_level,
                                 front_result.space_level, out_data.space_level);
                end
            end
        end
        // receiver stalls in bursts
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!quiet && rst_n && $urandom_range(0, 11) == 0)
                stall_left <= $urandom_range(1, 15);
        end
    end

    initial
    begin
        in_t         s;
        int          i;
        int          p;
        int          n;
        int          k;
        int          hp;
        int          amp;
        int          seg_len;
        bit          cmd_on;
        bit          cmd_mark;
        int unsigned mode;
        int unsigned m_inc;
        int unsigned s_inc;
        int unsigned lim;
        int unsigned on_d;
        int unsigned off_d;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table with reset registers, then again with extreme settings
        for (i = 0; i < N_DIRECTED; i++)
            send_sample(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);
        drain_results();
        set_registers(MODE_ORG, 127, 0, 0, 0, 1);
        @(posedge clk);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        cfg_we <= 1'b0;
        for (i = 0; i < N_DIRECTED; i++)
            send_sample(DIRECTED[i].stim, 1'b0, '0);
        drain_results();

        for (p = 0; p < N_PHASES; p++)
        begin
            mode  = p % 2;
            m_inc = (p == 2) ? 0 : (p == 3) ? 127 : $urandom_range(0, 127);
            s_inc = (p == 2) ? 127 : (p == 3) ? 0 : $urandom_range(0, 127);
            case (p % 5)
                0: lim = 0;
                1: lim = 255;
                2: lim = $urandom_range(1, 4);
                3: lim = $urandom_range(5, 40);
                default: lim = 1;
            endcase
            on_d  = (p == 4) ? 0 : (p == 5) ? 65535 : $urandom_range(1, 30);
            off_d = (p == 6) ? 65535 : (p == 7) ? 1 : (p == 8) ? 0 : $urandom_range(1, 30);
            set_registers(mode, m_inc, s_inc, lim, on_d, off_d);
            quiet = (p == 3 || p == 7 || p == N_PHASES - 1);

            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    // square-wave tone burst, negative half is ~amp so 127 gives -128
                    hp       = $urandom_range(1, 12);
                    amp      = $urandom_range(16, 127);
                    seg_len  = $urandom_range(16, 64);
                    cmd_on   = ($urandom_range(0, 3) != 0);
                    cmd_mark = $urandom_range(0, 1);
                    for (k = 0; k < seg_len && n < PHASE_ITEMS; k++)
                    begin
                        s.line_sample = ((k / hp) % 2 == 0) ? 8'(amp) : ~8'(amp);
                        s.send_on     = cmd_on;
                        s.send_mark   = cmd_mark;
                        if ($urandom_range(0, 15) == 0)
                            {s.send_on, s.send_mark} = 2'($urandom);
                        send_sample(s, 1'b0, '0);
                        n++;
                    end
                end
                else
                begin
                    seg_len = $urandom_range(4, 20);
                    for (k = 0; k < seg_len && n < PHASE_ITEMS; k++)
                    begin
                        s = in_t'(10'($urandom));
                        send_sample(s, 1'b0, '0);
                        n++;
                    end
                end
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
